>>> rtl/core/hfsp_pkg.sv
// Types, codes and label tables of the header field stream parser.
// Self-contained; imported by the parser top level and its checker.
package hfsp_pkg;

  // Field count and longest label ("Organization: ")
  localparam int NUM_FIELDS = 6;
  localparam int LABEL_MAX  = 14;

  // Result queue: two results per byte at most, one byte in flight
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  // Field numbers
  localparam logic [2:0] FIELD_DATE    = 3'd0;
  localparam logic [2:0] FIELD_TO      = 3'd1;
  localparam logic [2:0] FIELD_CC      = 3'd2;
  localparam logic [2:0] FIELD_FROM    = 3'd3;
  localparam logic [2:0] FIELD_ORG     = 3'd4;
  localparam logic [2:0] FIELD_SUBJECT = 3'd5;

  // Result status codes
  typedef enum logic [2:0] {
    ST_LABEL   = 3'd0,
    ST_VALUE   = 3'd1,
    ST_END     = 3'd2,
    ST_OK      = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_DUP     = 3'd5,
    ST_BAD     = 3'd6,
    ST_DISCARD = 3'd7
  } status_e;

  // Parser modes, one-hot
  typedef enum logic [4:0] {
    MODE_START   = 5'b00001,
    MODE_LABEL   = 5'b00010,
    MODE_VALUE   = 5'b00100,
    MODE_CR      = 5'b01000,
    MODE_DISCARD = 5'b10000
  } mode_e;

  // Input request
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_req_t;

  // Result request
  typedef struct packed {
    logic [2:0] field_id;
    logic [7:0] value_byte;
    logic [2:0] status;
    logic       run_last;
  } out_req_t;

  // Label text, first character in the top element
  typedef logic [LABEL_MAX-1:0][7:0] label_t;

  function automatic label_t label_text(logic [2:0] fid);
    label_t txt;
    case (fid)
      FIELD_DATE:    txt = {"Date: ",         {8{8'h00}}};
      FIELD_TO:      txt = {"To: ",           {10{8'h00}}};
      FIELD_CC:      txt = {"CC: ",           {10{8'h00}}};
      FIELD_FROM:    txt = {"From: ",         {8{8'h00}}};
      FIELD_ORG:     txt = "Organization: ";
      FIELD_SUBJECT: txt = {"Subject: ",      {5{8'h00}}};
      default:       txt = '0;
    endcase
    return txt;
  endfunction

  function automatic logic [3:0] label_len(logic [2:0] fid);
    logic [3:0] len;
    case (fid)
      FIELD_DATE:    len = 4'd6;
      FIELD_TO:      len = 4'd4;
      FIELD_CC:      len = 4'd4;
      FIELD_FROM:    len = 4'd6;
      FIELD_ORG:     len = 4'd14;
      FIELD_SUBJECT: len = 4'd9;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

  // Character at a position of a label, zero past the table
  function automatic logic [7:0] label_byte(logic [2:0] fid, logic [3:0] pos);
    label_t     txt;
    logic [7:0] chr;
    txt = label_text(fid);
    if (pos < 4'(LABEL_MAX)) begin
      chr = txt[4'(LABEL_MAX - 1) - pos];
    end else begin
      chr = 8'h00;
    end
    return chr;
  endfunction

  function automatic out_req_t mk_res(logic [2:0] fid, logic [7:0] vb, status_e st);
    out_req_t r;
    r.field_id   = fid;
    r.value_byte = vb;
    r.status     = st;
    r.run_last   = 1'b0;
    return r;
  endfunction

endpackage

>>> rtl/core/header_field_stream_parser_unit.sv
// Header field stream parser: top level with input register, parse logic
// and result queue. Depends on hfsp_pkg.
//
// The parser takes one header byte per cycle while in_stall_o is low and
// reports label matches, value bytes, field ends, buffer ends and errors
// as result requests. An accepted byte is parsed from the input register
// and its results (zero, one or two) are written from there into an
// eight-entry result queue. The output side delivers one result per cycle
// while out_stall_i is low; input stall rises only when the queue, the
// results of the byte in flight and those of a new byte could exceed its
// depth, so with the output side taking every cycle the block runs at one
// byte per cycle; where a byte yields two results (a lone CR before a
// value byte, or the closing LF of a buffer) the queue absorbs the extra.
module header_field_stream_parser_unit
  import hfsp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  // Input register
  logic    s1_valid_q;
  in_req_t s1_req_q;

  // Parser state
  logic [NUM_FIELDS-1:0] seen_q, seen_d;
  mode_e                 mode_q, mode_d;
  logic [2:0]            field_q, field_d;
  logic [3:0]            pos_q, pos_d;

  // Result queue
  out_req_t           fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;

  logic       accept_in, pop;
  logic [1:0] n_res;
  out_req_t   r0, r1;

  // Handshakes
  assign accept_in   = in_valid_i & ~in_stall_o;
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_req_o   = fifo_q[rd_ptr_q];
  assign in_stall_o  = (count_q + (s1_valid_q ? FIFO_CW'(2) : FIFO_CW'(0)))
                       > FIFO_CW'(FIFO_DEPTH - 2);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_req_q <= in_req_i;
    end
  end

  // Parse one byte: next state and up to two results
  always_comb begin
    logic [7:0] b;
    logic       hit;
    logic [2:0] first;
    logic [3:0] pos_inc;
    b       = s1_req_q.data_byte;
    hit     = 1'b0;
    first   = FIELD_DATE;
    pos_inc = pos_q + 4'd1;
    seen_d  = seen_q;
    mode_d  = mode_q;
    field_d = field_q;
    pos_d   = pos_q;
    n_res   = 2'd0;
    r0      = '0;
    r1      = '0;

    case (mode_q)
      MODE_START: begin
        // first letter picks the label
        for (int i = 0; i < NUM_FIELDS; i++) begin
          if (!hit && label_byte(3'(i), 4'd0) == b) begin
            hit   = 1'b1;
            first = 3'(i);
          end
        end
        if (!hit) begin
          r0     = mk_res(FIELD_DATE, 8'h00, ST_UNKNOWN);
          n_res  = 2'd1;
          mode_d = MODE_DISCARD;
        end else begin
          field_d = first;
          pos_d   = 4'd1;
          mode_d  = MODE_LABEL;
        end
      end
      MODE_LABEL: begin
        if (pos_q >= label_len(field_q) || label_byte(field_q, pos_q) != b) begin
          r0     = mk_res(field_q, 8'h00, ST_UNKNOWN);
          n_res  = 2'd1;
          mode_d = MODE_DISCARD;
        end else if (pos_inc == label_len(field_q)) begin
          pos_d = 4'd0;
          if (seen_q[field_q]) begin
            r0     = mk_res(field_q, 8'h00, ST_DUP);
            n_res  = 2'd1;
            mode_d = MODE_DISCARD;
          end else begin
            seen_d[field_q] = 1'b1;
            r0     = mk_res(field_q, 8'h00, ST_LABEL);
            n_res  = 2'd1;
            mode_d = MODE_VALUE;
          end
        end else begin
          pos_d = pos_inc;
        end
      end
      MODE_VALUE: begin
        if (b == CHAR_CR) begin
          mode_d = MODE_CR;
        end else begin
          r0    = mk_res(field_q, b, ST_VALUE);
          n_res = 2'd1;
        end
      end
      MODE_CR: begin
        if (b == CHAR_LF) begin
          r0     = mk_res(field_q, 8'h00, ST_END);
          n_res  = 2'd1;
          mode_d = MODE_START;
        end else if (b == CHAR_CR) begin
          r0    = mk_res(field_q, CHAR_CR, ST_VALUE);
          n_res = 2'd1;
        end else begin
          // lone CR goes out ahead of this byte
          r0     = mk_res(field_q, CHAR_CR, ST_VALUE);
          r1     = mk_res(field_q, b, ST_VALUE);
          n_res  = 2'd2;
          mode_d = MODE_VALUE;
        end
      end
      MODE_DISCARD: begin
        r0     = mk_res(FIELD_DATE, 8'h00, ST_DISCARD);
        n_res  = 2'd1;
        mode_d = MODE_DISCARD;
      end
      default: begin
        mode_d = MODE_DISCARD;
      end
    endcase

    // Buffer end: ok, bad syntax or nothing extra, then back to reset state
    if (s1_req_q.buffer_end) begin
      if (mode_d == MODE_START) begin
        if (n_res == 2'd0) begin
          r0 = mk_res(FIELD_DATE, 8'h00, ST_OK);
        end else begin
          r1 = mk_res(FIELD_DATE, 8'h00, ST_OK);
        end
        n_res = n_res + 2'd1;
      end else if (mode_d != MODE_DISCARD) begin
        r0    = mk_res(field_d, 8'h00, ST_BAD);
        n_res = 2'd1;
      end
      seen_d  = '0;
      mode_d  = MODE_START;
      field_d = FIELD_DATE;
      pos_d   = 4'd0;
    end

    // Mark the final result of this byte
    if (n_res == 2'd1) begin
      r0.run_last = 1'b1;
    end else if (n_res == 2'd2) begin
      r1.run_last = 1'b1;
    end

    if (!s1_valid_q) begin
      n_res   = 2'd0;
      seen_d  = seen_q;
      mode_d  = mode_q;
      field_d = field_q;
      pos_d   = pos_q;
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      mode_q  <= MODE_START;
      field_q <= FIELD_DATE;
      pos_q   <= 4'd0;
    end else begin
      seen_q  <= seen_d;
      mode_q  <= mode_d;
      field_q <= field_d;
      pos_q   <= pos_d;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_res);
      rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
      count_q  <= count_q + FIFO_CW'(n_res) - FIFO_CW'(pop);
    end
  end

  // Result queue storage
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      fifo_q[wr_ptr_q] <= r0;
    end
    if (n_res == 2'd2) begin
      fifo_q[wr_ptr_q + FIFO_AW'(1)] <= r1;
    end
  end

endmodule

>>> rtl/core/hfsp_checker.sv
// Port-level checker for the header field stream parser, bound to the top.
// Depends on hfsp_pkg.
module hfsp_checker
  import hfsp_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input in_req_t  in_req_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input out_req_t out_req_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))
    else $error("stalled result changed");

  // Value byte is zero outside value results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_req_o.status != ST_VALUE |-> out_req_o.value_byte == 8'h00)
    else $error("value byte set on non-value result");

  // Buffer ok and discarded are always the last result of their byte, field 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_req_o.status == ST_OK || out_req_o.status == ST_DISCARD)
    |-> out_req_o.run_last && out_req_o.field_id == FIELD_DATE)
    else $error("ok or discarded result malformed");

  // Field number stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_req_o.field_id < 3'(NUM_FIELDS))
    else $error("field number out of range");

  // An accepted input request carries known bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !$isunknown(in_req_i))
    else $error("accepted request has unknown bits");

endmodule

bind header_field_stream_parser_unit hfsp_checker u_hfsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);
